@@ hdl/rcnp_pkg.sv @@
// rcnp_pkg: shared constants, word types and the coil mask function
// for the ring coil needle positioner; no dependencies
`default_nettype none

package rcnp_pkg;

	localparam int NUM_COILS   = 16;
	localparam int NUM_SLOTS   = 2 * NUM_COILS;
	localparam int SLOT_W      = $clog2(NUM_SLOTS);
	localparam int COIL_W      = $clog2(NUM_COILS);
	localparam int MASK_W      = 16;
	localparam int TH_W        = 5;
	localparam int CNT_W       = $clog2(NUM_COILS + 1);
	localparam int MAX_RESULTS = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W        = $clog2(QUEUE_DEPTH);
	localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;
	localparam int REG_SEL_BIT = 2;

	localparam logic REG_NEAR = 1'b0;
	localparam logic REG_FAR  = 1'b1;

	localparam logic ACT_SEEK     = 1'b0;
	localparam logic ACT_CONVERGE = 1'b1;

	localparam logic [TH_W-1:0] NEAR_RESET = TH_W'(3);
	localparam logic [TH_W-1:0] FAR_RESET  = TH_W'(6);

	typedef struct packed {
		logic              action;
		logic [SLOT_W-1:0] target_slot;
	} in_word_t;

	typedef struct packed {
		logic [MASK_W-1:0] coil_mask;
		logic [SLOT_W-1:0] slot;
		logic              moved;
		logic              last;
	} out_word_t;

	typedef struct packed {
		logic [TH_W-1:0] near_threshold;
		logic [TH_W-1:0] far_threshold;
	} cfg_t;

	// count of zero means no move: one word with the current slot
	typedef struct packed {
		logic             fwd;
		logic [CNT_W-1:0] count;
	} cmd_t;

	function automatic logic [MASK_W-1:0] coil_mask_of(input logic [SLOT_W-1:0] s);
		logic [COIL_W-1:0] c;
		logic [MASK_W-1:0] m;
		c = s[SLOT_W-1:1];
		m = '0;
		m[c] = 1'b1;
		if (s[0]) begin
			m[c + COIL_W'(1)] = 1'b1;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

@@ hdl/rcnp_front.sv @@
// rcnp_front: accepts input words, picks direction and step count
// from its own copy of the slot; uses rcnp_pkg
`default_nettype none

module rcnp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire rcnp_pkg::in_word_t item,
	input  wire rcnp_pkg::cfg_t    cfg,
	input  wire logic              q_full,
	output logic                   q_push,
	output rcnp_pkg::cmd_t         q_cmd
);
	import rcnp_pkg::*;

	localparam logic [SLOT_W-1:0] HALF = SLOT_W'(NUM_COILS);

	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] fwd_dist;
	logic [SLOT_W-1:0] ring_dist;
	logic [CNT_W-1:0]  dist_c;
	logic [CNT_W-1:0]  lim;
	logic [CNT_W-1:0]  count;
	logic              forward;

	always_comb begin
		fwd_dist  = item.target_slot - slot_q;
		forward   = (fwd_dist != '0) && (fwd_dist < HALF);
		ring_dist = (fwd_dist <= HALF) ? fwd_dist : (SLOT_W'(0) - fwd_dist);
		dist_c    = CNT_W'(ring_dist);
		lim       = CNT_W'(1);
		if (item.action == ACT_SEEK) begin
			lim = CNT_W'(MAX_RESULTS);
		end else begin
			if (ring_dist > SLOT_W'(cfg.near_threshold)) begin
				lim = CNT_W'(2);
			end
			if ((ring_dist > SLOT_W'(cfg.far_threshold)) && (item.target_slot < HALF)) begin
				lim = CNT_W'(3);
			end
		end
		if (fwd_dist == '0) begin
			count = '0;
		end else begin
			count = (lim < dist_c) ? lim : dist_c;
		end
	end

	assign item_stall  = q_full;
	assign q_push      = item_valid && !q_full;
	assign q_cmd.fwd   = forward;
	assign q_cmd.count = count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (q_push) begin
			if (forward) begin
				slot_q <= slot_q + SLOT_W'(count);
			end else begin
				slot_q <= slot_q - SLOT_W'(count);
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/rcnp_queue.sv @@
// rcnp_queue: short command queue between front and back
// uses rcnp_pkg
`default_nettype none

module rcnp_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire rcnp_pkg::cmd_t push_cmd,
	input  wire logic           pop,
	output logic                full,
	output logic                not_empty,
	output rcnp_pkg::cmd_t      head
);
	import rcnp_pkg::*;

	cmd_t            entry_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] fill_q;

	assign full      = (fill_q == QC_W'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + QC_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - QC_W'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
`endif

endmodule

`default_nettype wire

@@ hdl/rcnp_back.sv @@
// rcnp_back: steps the needle one slot per word and drives the result
// register; uses rcnp_pkg
`default_nettype none

module rcnp_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire rcnp_pkg::cmd_t cmd,
	output logic                pop,
	output logic                result_valid,
	input  wire logic           result_stall,
	output rcnp_pkg::out_word_t result
);
	import rcnp_pkg::*;

	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              rv_q;
	out_word_t         res_q;
	logic              load;
	logic              fire;
	logic              no_move;
	logic              last;
	logic [SLOT_W-1:0] next_slot;

	always_comb begin
		load    = !rv_q || !result_stall;
		fire    = cmd_valid && load;
		no_move = (cmd.count == '0);
		last    = no_move || ((cnt_q + CNT_W'(1)) == cmd.count);
		if (no_move) begin
			next_slot = slot_q;
		end else if (cmd.fwd) begin
			next_slot = slot_q + SLOT_W'(1);
		end else begin
			next_slot = slot_q - SLOT_W'(1);
		end
	end

	assign pop          = fire && last;
	assign result_valid = rv_q;
	assign result       = res_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.coil_mask <= coil_mask_of(next_slot);
			res_q.slot      <= next_slot;
			res_q.moved     <= !no_move;
			res_q.last      <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			cnt_q  <= '0;
			rv_q   <= 1'b0;
		end else begin
			if (fire) begin
				slot_q <= next_slot;
				cnt_q  <= last ? '0 : cnt_q + CNT_W'(1);
				rv_q   <= 1'b1;
			end else if (load) begin
				rv_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_idle_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_q && !res_q.moved) |-> res_q.last) else $error("no-move word not last");
	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !no_move) |-> (cnt_q < cmd.count)) else $error("step count overrun");
`endif

endmodule

`default_nettype wire

@@ hdl/ring_coil_needle_positioner.sv @@
// ring_coil_needle_positioner: top level with threshold registers
// depends on rcnp_pkg, rcnp_front, rcnp_queue, rcnp_back
//
//   port group  direction  contents
//   item        in         action, target_slot; item_valid / item_stall
//   result      out        coil_mask, slot, moved, last; result_valid / result_stall
//   apb         in/out     near_threshold at 0x0, far_threshold at 0x4
//
// an item enters the two-entry queue in the cycle it is accepted
// the back emits one word per cycle while result_stall is low: an item with n
// steps gives n words, one word when no move is needed, sixteen at most
// reset puts the needle at slot 0 and thresholds at 3 and 6
// item_stall rises only while the queue is full; result_stall holds the word
`default_nettype none

module ring_coil_needle_positioner (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire rcnp_pkg::in_word_t            item,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output rcnp_pkg::out_word_t                result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rcnp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [rcnp_pkg::DATA_W-1:0]   pwdata,
	output logic [rcnp_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import rcnp_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic q_full;
	logic q_push;
	logic q_not_empty;
	logic q_pop;
	cmd_t push_cmd;
	cmd_t head_cmd;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_threshold <= NEAR_RESET;
			cfg_q.far_threshold  <= FAR_RESET;
		end else if (wr_en) begin
			case (paddr[REG_SEL_BIT])
				REG_NEAR: cfg_q.near_threshold <= pwdata[TH_W-1:0];
				REG_FAR:  cfg_q.far_threshold  <= pwdata[TH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[REG_SEL_BIT])
			REG_NEAR: prdata = DATA_W'(cfg_q.near_threshold);
			REG_FAR:  prdata = DATA_W'(cfg_q.far_threshold);
			default:  prdata = '0;
		endcase
	end

	rcnp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg        (cfg_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (push_cmd)
	);

	rcnp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head_cmd)
	);

	rcnp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_not_empty),
		.cmd          (head_cmd),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
